[sv/ldb_pkg.sv]
// Shared types and constants for the linear date binning unit.
package ldb_pkg;

  localparam int MAX_BUCKETS = 32;
  localparam int IDX_W = $clog2(MAX_BUCKETS);
  localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
  localparam int DAY_W = 17;
  localparam int VAL_W = 48;
  localparam int PROD_W = VAL_W + DAY_W - 1;
  localparam int STEP_W = $clog2(VAL_W + 1);

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_FLOW  = 2'd1,
    FN_READ  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NOBK = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_WAIT,
    S_PROBE_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_EARLY_WAIT,
    S_MULDIV,
    S_LATER_RD,
    S_LATER_WR,
    S_ADD_RD,
    S_ADD_WR,
    S_RO_RD,
    S_RO_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef enum logic [2:0] {
    RA_MID,
    RA_LO,
    RA_LO_M1,
    RA_J_M1,
    RA_J,
    RA_TGT
  } raddr_sel_t;

  typedef enum logic [1:0] {
    TGT_LAST,
    TGT_IDX,
    TGT_LATER,
    TGT_EARLIER
  } tgt_t;

  typedef struct packed {
    logic       latch_in;
    logic       clear_all;
    logic       srch_rd;
    logic       srch_upd;
    raddr_sel_t raddr_sel;
    logic       zero_sum;
    logic       shift_init;
    logic       shift_wr;
    logic       insert;
    logic       md_start;
    logic       set_tgt;
    tgt_t       tgt_kind;
    logic       rmw_wr;
    logic       ro_init;
    logic       ro_next;
    logic       emit;
    logic       emit_entry;
    status_t    st;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic count_zero;
    logic full;
    logic search_go;
    logic eq;
    logic idx_ge_cnt;
    logic idx_zero;
    logic shift_go;
    logic ro_last;
    logic md_done;
  } dp_stat_t;

endpackage

[sv/ldb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ldb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ldb_muldiv.sv]
// Serial multiply then restoring divide: quot = mag * num / den.
module ldb_muldiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ldb_pkg::VAL_W-1:0]  mag,
  input  logic [ldb_pkg::DAY_W-1:0]  num,
  input  logic [ldb_pkg::DAY_W-1:0]  den,
  output logic                       done,
  output logic [ldb_pkg::VAL_W-1:0]  quot
);

  localparam int VW = ldb_pkg::VAL_W;
  localparam int DW = ldb_pkg::DAY_W;
  localparam int PW = ldb_pkg::PROD_W;
  localparam int SW = ldb_pkg::STEP_W;

  ldb_pkg::md_state_t state, state_next;

  logic [SW-1:0] cnt;
  logic [PW-1:0] mcand;
  logic [DW-1:0] mlt;
  logic [PW-1:0] acc;
  logic [DW-1:0] rem;
  logic [VW-1:0] dvd;
  logic [DW-1:0] den_r;
  logic          done_r;

  logic [PW-1:0] acc_next;
  logic [DW:0]   trial;
  logic          qbit;
  logic          mul_end;
  logic          div_end;

  assign acc_next = mlt[0] ? acc + mcand : acc;
  assign trial    = {rem, dvd[VW-1]};
  assign qbit     = trial >= {1'b0, den_r};
  assign mul_end  = cnt == SW'(DW - 1);
  assign div_end  = cnt == SW'(VW - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldb_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ldb_pkg::MD_IDLE: if (start) state_next = ldb_pkg::MD_MUL;
      ldb_pkg::MD_MUL:  if (mul_end) state_next = ldb_pkg::MD_DIV;
      ldb_pkg::MD_DIV:  if (div_end) state_next = ldb_pkg::MD_IDLE;
      default:          state_next = ldb_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_r <= 1'b0;
    end else if (start) begin
      done_r <= 1'b0;
    end else if (state == ldb_pkg::MD_DIV && div_end) begin
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ldb_pkg::MD_IDLE: begin
        if (start) begin
          mcand <= PW'(mag);
          mlt   <= num;
          acc   <= '0;
          den_r <= den;
          cnt   <= '0;
        end
      end
      ldb_pkg::MD_MUL: begin
        acc   <= acc_next;
        mcand <= mcand << 1;
        mlt   <= mlt >> 1;
        if (mul_end) begin
          // quotient fits VAL_W bits, so the top bits are already below den
          rem <= DW'(acc_next[PW-1:VW]);
          dvd <= acc_next[VW-1:0];
          cnt <= '0;
        end else begin
          cnt <= cnt + SW'(1);
        end
      end
      ldb_pkg::MD_DIV: begin
        rem <= qbit ? DW'(trial - {1'b0, den_r}) : DW'(trial);
        dvd <= {dvd[VW-2:0], qbit};
        cnt <= cnt + SW'(1);
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign quot = dvd;

endmodule

[sv/ldb_datapath.sv]
// Datapath: bucket tables, search pointers, split arithmetic, result register.
module ldb_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  ldb_pkg::dp_cmd_t          cmd,
  input  logic [1:0]                func_in,
  input  logic [ldb_pkg::DAY_W-1:0] day_in,
  input  logic [ldb_pkg::VAL_W-1:0] amt_in,
  output ldb_pkg::dp_stat_t         stat,
  output logic                      strobe,
  output logic [ldb_pkg::DAY_W-1:0] bucket_day,
  output logic [ldb_pkg::VAL_W-1:0] bucket_sum,
  output logic [1:0]                status,
  output logic                      last
);

  localparam int IW = ldb_pkg::IDX_W;
  localparam int CW = ldb_pkg::CNT_W;
  localparam int DW = ldb_pkg::DAY_W;
  localparam int VW = ldb_pkg::VAL_W;

  ldb_pkg::func_t func_r;
  logic [DW-1:0]  day_r;
  logic [VW-1:0]  amt_r;
  logic [CW-1:0]  count;
  logic [CW-1:0]  lo;
  logic [CW-1:0]  hi;
  logic [IW-1:0]  mid;
  logic [CW-1:0]  j;
  logic [DW-1:0]  late;
  logic [IW-1:0]  tgt;
  logic [VW-1:0]  addv;

  logic [IW-1:0]  mid_c;
  logic [IW-1:0]  raddr;
  logic [DW-1:0]  days_rd;
  logic [VW-1:0]  sums_rd;
  logic           days_we;
  logic [IW-1:0]  days_waddr;
  logic [DW-1:0]  days_wdata;
  logic           sums_we;
  logic [IW-1:0]  sums_waddr;
  logic [VW-1:0]  sums_wdata;

  logic [VW-1:0]  mag;
  logic           md_done;
  logic [VW-1:0]  quot;
  logic [VW-1:0]  later_c;

  logic           strobe_r;
  logic [DW-1:0]  day_o;
  logic [VW-1:0]  sum_o;
  logic [1:0]     st_o;
  logic           last_o;

  assign mid_c = IW'(lo + ((hi - lo) >> 1));

  always_comb begin
    unique case (cmd.raddr_sel)
      ldb_pkg::RA_MID:   raddr = mid_c;
      ldb_pkg::RA_LO:    raddr = lo[IW-1:0];
      ldb_pkg::RA_LO_M1: raddr = IW'(lo - CW'(1));
      ldb_pkg::RA_J_M1:  raddr = IW'(j - CW'(1));
      ldb_pkg::RA_J:     raddr = j[IW-1:0];
      ldb_pkg::RA_TGT:   raddr = tgt;
      default:           raddr = mid_c;
    endcase
  end

  assign days_we    = cmd.shift_wr | cmd.insert;
  assign days_waddr = cmd.insert ? lo[IW-1:0] : j[IW-1:0];
  assign days_wdata = cmd.insert ? day_r : days_rd;

  always_comb begin
    sums_we    = cmd.shift_wr | cmd.insert | cmd.zero_sum | cmd.rmw_wr;
    sums_waddr = lo[IW-1:0];
    sums_wdata = '0;
    if (cmd.shift_wr) begin
      sums_waddr = j[IW-1:0];
      sums_wdata = sums_rd;
    end else if (cmd.rmw_wr) begin
      sums_waddr = tgt;
      sums_wdata = sums_rd + addv;
    end
  end

  ldb_ram #(.WIDTH(DW), .DEPTH(ldb_pkg::MAX_BUCKETS)) u_days (
    .clk   (clk),
    .we    (days_we),
    .waddr (days_waddr),
    .wdata (days_wdata),
    .raddr (raddr),
    .rdata (days_rd)
  );

  ldb_ram #(.WIDTH(VW), .DEPTH(ldb_pkg::MAX_BUCKETS)) u_sums (
    .clk   (clk),
    .we    (sums_we),
    .waddr (sums_waddr),
    .wdata (sums_wdata),
    .raddr (raddr),
    .rdata (sums_rd)
  );

  // magnitude of the flow; the most negative value maps to 2^47 as wanted
  assign mag     = amt_r[VW-1] ? (~amt_r + VW'(1)) : amt_r;
  assign later_c = amt_r[VW-1] ? (~quot + VW'(1)) : quot;

  ldb_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.md_start),
    .mag   (mag),
    .num   (day_r - days_rd),
    .den   (late - days_rd),
    .done  (md_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_all) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_r <= ldb_pkg::func_t'(func_in);
      day_r  <= day_in;
      amt_r  <= amt_in;
      lo     <= '0;
      hi     <= count;
    end
    if (cmd.srch_rd) begin
      mid <= mid_c;
    end
    if (cmd.srch_upd) begin
      if (days_rd < day_r) begin
        lo <= CW'(mid) + CW'(1);
      end else begin
        hi <= CW'(mid);
      end
    end
    if (cmd.shift_init) begin
      j <= count;
    end else if (cmd.shift_wr) begin
      j <= j - CW'(1);
    end else if (cmd.ro_init) begin
      j <= '0;
    end else if (cmd.ro_next) begin
      j <= j + CW'(1);
    end
    if (cmd.set_tgt) begin
      unique case (cmd.tgt_kind)
        ldb_pkg::TGT_LAST: begin
          tgt  <= IW'(count - CW'(1));
          addv <= amt_r;
        end
        ldb_pkg::TGT_IDX: begin
          tgt  <= lo[IW-1:0];
          addv <= amt_r;
        end
        ldb_pkg::TGT_LATER: begin
          tgt  <= lo[IW-1:0];
          addv <= later_c;
        end
        ldb_pkg::TGT_EARLIER: begin
          tgt  <= IW'(lo - CW'(1));
          addv <= amt_r - addv;
        end
        default: ;
      endcase
    end
  end

  // later bucket date, taken when the probe read returns
  always_ff @(posedge clk) begin
    if (stat.idx_ge_cnt == 1'b0 && cmd.srch_rd == 1'b0 && cmd.srch_upd == 1'b0 &&
        cmd.raddr_sel == ldb_pkg::RA_LO_M1) begin
      late <= days_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_entry) begin
        day_o  <= days_rd;
        sum_o  <= sums_rd;
        st_o   <= ldb_pkg::ST_OK;
        last_o <= stat.ro_last;
      end else begin
        day_o  <= '0;
        sum_o  <= '0;
        st_o   <= cmd.st;
        last_o <= 1'b1;
      end
    end
  end

  assign stat.is_load    = func_r == ldb_pkg::FN_LOAD;
  assign stat.count_zero = count == '0;
  assign stat.full       = count == CW'(ldb_pkg::MAX_BUCKETS);
  assign stat.search_go  = lo < hi;
  assign stat.eq         = (lo < count) && (days_rd == day_r);
  assign stat.idx_ge_cnt = lo >= count;
  assign stat.idx_zero   = lo == '0;
  assign stat.shift_go   = j > lo;
  assign stat.ro_last    = (j + CW'(1)) == count;
  assign stat.md_done    = md_done;

  assign strobe     = strobe_r;
  assign bucket_day = day_o;
  assign bucket_sum = sum_o;
  assign status     = st_o;
  assign last       = last_o;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ldb_pkg::MAX_BUCKETS))
    else $error("bucket count above table size");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert into full table");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (strobe_r && st_o != ldb_pkg::ST_OK) |-> last_o)
    else $error("error result not marked last");

endmodule

[sv/ldb_ctrl.sv]
// Controller state machine: sequences search, insert, split and readout.
module ldb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  ldb_pkg::dp_stat_t stat,
  output ldb_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  ldb_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.raddr_sel = ldb_pkg::RA_MID;
    cmd.tgt_kind  = ldb_pkg::TGT_IDX;
    cmd.st        = ldb_pkg::ST_OK;
    unique case (state)
      ldb_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          unique case (ldb_pkg::func_t'(func))
            ldb_pkg::FN_LOAD: state_next = ldb_pkg::S_SRCH;
            ldb_pkg::FN_FLOW: begin
              if (stat.count_zero) begin
                cmd.emit = 1'b1;
                cmd.st   = ldb_pkg::ST_NOBK;
              end else begin
                state_next = ldb_pkg::S_SRCH;
              end
            end
            ldb_pkg::FN_READ: begin
              if (stat.count_zero) begin
                cmd.emit = 1'b1;
                cmd.st   = ldb_pkg::ST_NOBK;
              end else begin
                cmd.ro_init = 1'b1;
                state_next  = ldb_pkg::S_RO_RD;
              end
            end
            ldb_pkg::FN_CLEAR: begin
              cmd.clear_all = 1'b1;
              cmd.emit      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ldb_pkg::S_SRCH: begin
        if (stat.search_go) begin
          cmd.srch_rd   = 1'b1;
          cmd.raddr_sel = ldb_pkg::RA_MID;
          state_next    = ldb_pkg::S_SRCH_WAIT;
        end else begin
          cmd.raddr_sel = ldb_pkg::RA_LO;
          state_next    = ldb_pkg::S_PROBE_WAIT;
        end
      end
      ldb_pkg::S_SRCH_WAIT: begin
        cmd.srch_upd = 1'b1;
        state_next   = ldb_pkg::S_SRCH;
      end
      ldb_pkg::S_PROBE_WAIT: begin
        if (stat.is_load) begin
          if (stat.eq) begin
            cmd.zero_sum = 1'b1;
            cmd.emit     = 1'b1;
            state_next   = ldb_pkg::S_IDLE;
          end else if (stat.full) begin
            cmd.emit   = 1'b1;
            cmd.st     = ldb_pkg::ST_FULL;
            state_next = ldb_pkg::S_IDLE;
          end else begin
            cmd.shift_init = 1'b1;
            state_next     = ldb_pkg::S_SHIFT_RD;
          end
        end else if (stat.idx_ge_cnt) begin
          cmd.set_tgt  = 1'b1;
          cmd.tgt_kind = ldb_pkg::TGT_LAST;
          state_next   = ldb_pkg::S_ADD_RD;
        end else if (stat.idx_zero || stat.eq) begin
          cmd.set_tgt  = 1'b1;
          cmd.tgt_kind = ldb_pkg::TGT_IDX;
          state_next   = ldb_pkg::S_ADD_RD;
        end else begin
          // capture later date now, fetch the earlier one
          cmd.raddr_sel = ldb_pkg::RA_LO_M1;
          state_next    = ldb_pkg::S_EARLY_WAIT;
        end
      end
      ldb_pkg::S_SHIFT_RD: begin
        if (stat.shift_go) begin
          cmd.raddr_sel = ldb_pkg::RA_J_M1;
          state_next    = ldb_pkg::S_SHIFT_WR;
        end else begin
          cmd.insert = 1'b1;
          cmd.emit   = 1'b1;
          state_next = ldb_pkg::S_IDLE;
        end
      end
      ldb_pkg::S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ldb_pkg::S_SHIFT_RD;
      end
      ldb_pkg::S_EARLY_WAIT: begin
        cmd.md_start = 1'b1;
        state_next   = ldb_pkg::S_MULDIV;
      end
      ldb_pkg::S_MULDIV: begin
        if (stat.md_done) begin
          cmd.set_tgt  = 1'b1;
          cmd.tgt_kind = ldb_pkg::TGT_LATER;
          state_next   = ldb_pkg::S_LATER_RD;
        end
      end
      ldb_pkg::S_LATER_RD: begin
        cmd.raddr_sel = ldb_pkg::RA_TGT;
        state_next    = ldb_pkg::S_LATER_WR;
      end
      ldb_pkg::S_LATER_WR: begin
        cmd.rmw_wr   = 1'b1;
        cmd.set_tgt  = 1'b1;
        cmd.tgt_kind = ldb_pkg::TGT_EARLIER;
        state_next   = ldb_pkg::S_ADD_RD;
      end
      ldb_pkg::S_ADD_RD: begin
        cmd.raddr_sel = ldb_pkg::RA_TGT;
        state_next    = ldb_pkg::S_ADD_WR;
      end
      ldb_pkg::S_ADD_WR: begin
        cmd.rmw_wr = 1'b1;
        cmd.emit   = 1'b1;
        state_next = ldb_pkg::S_IDLE;
      end
      ldb_pkg::S_RO_RD: begin
        cmd.raddr_sel = ldb_pkg::RA_J;
        state_next    = ldb_pkg::S_RO_EMIT;
      end
      ldb_pkg::S_RO_EMIT: begin
        cmd.emit       = 1'b1;
        cmd.emit_entry = 1'b1;
        cmd.ro_next    = 1'b1;
        state_next     = stat.ro_last ? ldb_pkg::S_IDLE : ldb_pkg::S_RO_RD;
      end
      default: state_next = ldb_pkg::S_IDLE;
    endcase
  end

  assign busy = state != ldb_pkg::S_IDLE;

endmodule

[sv/linear_date_binning_unit.sv]
// Linear date binning unit: top level joining controller and datapath.
//
// Keeps up to 32 bucket dates in ascending order, each with a 48-bit wrapping
// sum (signed, 16 fraction bits). A command is taken when start is high and
// busy is low; func selects load date, add flow, read out or clear. Every
// result shows on the result ports for exactly one cycle with strobe high and
// must be taken then: the receiver cannot hold results off. Acknowledges are
// single results with last set; a readout gives one result per bucket in
// ascending date order, last on the final one. The block works on one
// command at a time. Timing is set by the binary search over the date RAM
// (at most 6 probes, each a read then an update), the RAM read-modify-write
// path, the shifting of later buckets up by one place on a load and, for a
// split flow, the serial multiply and the restoring divide.
module linear_date_binning_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic [ldb_pkg::DAY_W-1:0]        day,
  input  logic signed [ldb_pkg::VAL_W-1:0] amount,
  output logic                             strobe,
  output logic [ldb_pkg::DAY_W-1:0]        bucket_day,
  output logic signed [ldb_pkg::VAL_W-1:0] bucket_sum,
  output logic [1:0]                       status,
  output logic                             last
);

  // command and status between the two halves
  ldb_pkg::dp_cmd_t  cmd;
  ldb_pkg::dp_stat_t stat;
  logic [ldb_pkg::VAL_W-1:0] sum_u;

  ldb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ldb_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func_in    (func),
    .day_in     (day),
    .amt_in     (amount),
    .stat       (stat),
    .strobe     (strobe),
    .bucket_day (bucket_day),
    .bucket_sum (sum_u),
    .status     (status),
    .last       (last)
  );

  assign bucket_sum = sum_u;

endmodule

[dv/tb_linear_date_binning_unit.sv]
// Testbench for the linear date binning unit: directed and random commands, scoreboard.
`timescale 1ns / 1ps

module tb_linear_date_binning_unit;

  localparam int  ITEMS_TARGET = 360;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  DRAIN_CYCLES = 200;
  localparam int  REPORT_MAX   = 10;
  localparam int  DW = ldb_pkg::DAY_W;
  localparam int  VW = ldb_pkg::VAL_W;
  localparam int  NB = ldb_pkg::MAX_BUCKETS;

  // One expected result transfer.
  typedef struct packed {
    logic [DW-1:0] bday;
    logic [VW-1:0] bsum;
    logic [1:0]    st;
    logic          fin;
  } bin_result_t;

  // Mirror of the bucket table; expectations queued per accepted command.
  class bin_scoreboard;
    logic [DW-1:0] day_tab[NB];
    logic [VW-1:0] sum_tab[NB];
    int            count;
    bin_result_t   pending_q[$];
    int            errors;

    function new();
      count  = 0;
      errors = 0;
      foreach (sum_tab[k]) begin
        sum_tab[k] = '0;
        day_tab[k] = '0;
      end
    endfunction

    // first bucket at or after d; count if none
    function int first_at_or_after(logic [DW-1:0] d);
      int lo, hi, mid;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (day_tab[mid] < d) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void push(logic [DW-1:0] d, logic [VW-1:0] s, ldb_pkg::status_t st,
                       logic fin);
      bin_result_t r;
      r.bday = d;
      r.bsum = s;
      r.st   = st;
      r.fin  = fin;
      pending_q.push_back(r);
    endfunction

    function ldb_pkg::status_t load_day(logic [DW-1:0] d);
      int i;
      i = first_at_or_after(d);
      if (i < count && day_tab[i] == d) begin
        sum_tab[i] = '0;
        return ldb_pkg::ST_OK;
      end
      if (count >= NB) return ldb_pkg::ST_FULL;
      for (int j = count; j > i; j--) begin
        day_tab[j] = day_tab[j-1];
        sum_tab[j] = sum_tab[j-1];
      end
      day_tab[i] = d;
      sum_tab[i] = '0;
      count++;
      return ldb_pkg::ST_OK;
    endfunction

    // Nearest bucket takes all; in between, split by day distance.
    function ldb_pkg::status_t bin_flow(logic [DW-1:0] d, logic [VW-1:0] a);
      int            i;
      logic [DW-1:0] num, den;
      logic [VW-1:0] mag, later_share;
      logic [63:0]   quo;
      if (count == 0) return ldb_pkg::ST_NOBK;
      i = first_at_or_after(d);
      if (i >= count) begin
        sum_tab[count-1] += a;
      end else if (i == 0 || day_tab[i] == d) begin
        sum_tab[i] += a;
      end else begin
        num = d - day_tab[i-1];
        den = day_tab[i] - day_tab[i-1];
        mag = a[VW-1] ? -a : a;
        quo = (64'(mag) * 64'(num)) / 64'(den);
        later_share = a[VW-1] ? -quo[VW-1:0] : quo[VW-1:0];
        sum_tab[i]   += later_share;
        sum_tab[i-1] += a - later_share;
      end
      return ldb_pkg::ST_OK;
    endfunction

    function void note_command(ldb_pkg::func_t f, logic [DW-1:0] d, logic [VW-1:0] a);
      case (f)
        ldb_pkg::FN_LOAD: push('0, '0, load_day(d), 1'b1);
        ldb_pkg::FN_FLOW: push('0, '0, bin_flow(d, a), 1'b1);
        ldb_pkg::FN_READ: begin
          if (count == 0) push('0, '0, ldb_pkg::ST_NOBK, 1'b1);
          else
            for (int k = 0; k < count; k++)
              push(day_tab[k], sum_tab[k], ldb_pkg::ST_OK, k == count - 1);
        end
        default: begin
          foreach (sum_tab[k]) sum_tab[k] = '0;
          count = 0;
          push('0, '0, ldb_pkg::ST_OK, 1'b1);
        end
      endcase
    endfunction

    function void check_result(bin_result_t got);
      bin_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: unexpected result day=%0d sum=%h status=%0d last=%0b",
                   got.bday, got.bsum, got.st, got.fin);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("ERROR: result mismatch exp day=%0d sum=%h status=%0d last=%0b",
                   want.bday, want.bsum, want.st, want.fin);
          $display("                       got day=%0d sum=%h status=%0d last=%0b",
                   got.bday, got.bsum, got.st, got.fin);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           func = ldb_pkg::FN_LOAD;
  logic [DW-1:0]        day = '0;
  logic signed [VW-1:0] amount = '0;
  logic                 strobe;
  logic [DW-1:0]        bucket_day;
  logic signed [VW-1:0] bucket_sum;
  logic [1:0]           status;
  logic                 last;

  bin_scoreboard sb = new();
  int            cycles = 0;
  int            sent = 0;

  always #4 clk = ~clk;

  linear_date_binning_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .day        (day),
    .amount     (amount),
    .strobe     (strobe),
    .bucket_day (bucket_day),
    .bucket_sum (bucket_sum),
    .status     (status),
    .last       (last)
  );

  // Results cannot be held off, so every strobe is checked on the edge it ends.
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result({bucket_day, bucket_sum, status, last});
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive one command at the falling edge; busy only moves at rising edges, so
  // the value seen at a falling edge is the one the next rising edge uses.
  task automatic issue(ldb_pkg::func_t f, logic [DW-1:0] d, logic [VW-1:0] a);
    @(negedge clk);
    func   = f;
    day    = d;
    amount = a;
    start  = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_command(f, d, a);
    sent++;
  endtask

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      func  = 2'($urandom_range(0, 3));
      day   = DW'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic [VW-1:0] rand_amount();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return {1'b1, {(VW-1){1'b0}}};
      1: return {1'b0, {(VW-1){1'b1}}};
      2: return '1;
      3: return VW'($urandom_range(0, 1000)) << 16;
      default: return VW'({$urandom, $urandom});
    endcase
  endfunction

  // Flow dates near the table: on a bucket, just around one, or anywhere.
  function automatic logic [DW-1:0] rand_flow_day();
    int k;
    if (sb.count == 0 || $urandom_range(0, 3) == 0) return DW'($urandom);
    k = $urandom_range(0, sb.count - 1);
    case ($urandom_range(0, 2))
      0: return sb.day_tab[k];
      1: return sb.day_tab[k] + DW'($urandom_range(0, 3000));
      default: return sb.day_tab[k] - DW'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic directed_part();
    issue(ldb_pkg::FN_READ,  17'd0, '0);               // readout of empty table
    issue(ldb_pkg::FN_FLOW,  17'd500, rand_amount());  // flow with no buckets
    issue(ldb_pkg::FN_LOAD,  17'd1000, '0);
    issue(ldb_pkg::FN_FLOW,  17'd0, 48'sd65536);       // single bucket
    issue(ldb_pkg::FN_LOAD,  17'd0, '0);
    issue(ldb_pkg::FN_LOAD,  17'h1FFFF, '0);
    issue(ldb_pkg::FN_LOAD,  17'd2000, '0);
    issue(ldb_pkg::FN_LOAD,  17'd1000, '0);            // duplicate date
    issue(ldb_pkg::FN_FLOW,  17'd1000, {1'b0, {(VW-1){1'b1}}}); // on a bucket
    issue(ldb_pkg::FN_FLOW,  17'd1500, {1'b1, {(VW-1){1'b0}}}); // split, most negative
    issue(ldb_pkg::FN_FLOW,  17'd1999, {1'b0, {(VW-1){1'b1}}}); // split, most positive
    issue(ldb_pkg::FN_FLOW,  17'd1001, -48'sd7);       // split, small negative
    issue(ldb_pkg::FN_FLOW,  17'h1FFFE, 48'sd123456789);
    issue(ldb_pkg::FN_READ,  17'd0, '0);
    issue(ldb_pkg::FN_CLEAR, 17'd0, '0);
    issue(ldb_pkg::FN_FLOW,  17'd1000, 48'sd1);
    issue(ldb_pkg::FN_LOAD,  17'd50, '0);
    issue(ldb_pkg::FN_FLOW,  17'd10, -48'sd99);        // before the first bucket
    issue(ldb_pkg::FN_FLOW,  17'd90000, 48'sd99);      // after the last bucket
    issue(ldb_pkg::FN_READ,  17'd0, '0);
  endtask

  // Well-formed episodes: optional clear, loads, flows, readout; plus noise.
  task automatic random_part();
    int nload, nflow, base, spread;
    while (sent < ITEMS_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        issue(ldb_pkg::FN_CLEAR, DW'($urandom), rand_amount());
        idle_gap();
      end
      nload  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      base   = $urandom_range(0, 131071);
      spread = ($urandom_range(0, 1) == 0) ? 200 : 131071;
      for (int k = 0; k < nload; k++) begin
        if (sb.count > 0 && $urandom_range(0, 7) == 0)
          issue(ldb_pkg::FN_LOAD, sb.day_tab[$urandom_range(0, sb.count - 1)],
                rand_amount());
        else
          issue(ldb_pkg::FN_LOAD, DW'(base + $urandom_range(0, spread)), rand_amount());
        idle_gap();
      end
      nflow = $urandom_range(1, 10);
      for (int k = 0; k < nflow; k++) begin
        issue(ldb_pkg::FN_FLOW, rand_flow_day(), rand_amount());
        idle_gap();
      end
      if ($urandom_range(0, 4) == 0) begin
        issue(ldb_pkg::func_t'($urandom_range(0, 3)), DW'($urandom), rand_amount());
        idle_gap();
      end
      issue(ldb_pkg::FN_READ, DW'($urandom), rand_amount());
      idle_gap();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_part();
    random_part();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
sv/ldb_pkg.sv
sv/ldb_ram.sv
sv/ldb_muldiv.sv
sv/ldb_datapath.sv
sv/ldb_ctrl.sv
sv/linear_date_binning_unit.sv
dv/tb_linear_date_binning_unit.sv
